FILE: hdl/opw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package opw_pkg;

   localparam int RADIUS_DEFAULT    = 5;
   localparam int LEVELS_DEFAULT    = 20;
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MAX_HEIGHT        = 4096;

   localparam int FW_W        = 11;
   localparam int FH_W        = 13;
   localparam int ROW_W       = 12;
   localparam int TK_COL_W    = 12;
   localparam int TK_ADDR_W   = 16;
   localparam int PIX_W       = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   typedef struct packed {
      logic       op;
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       end_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [ROW_W-1:0]     row;
      logic [TK_COL_W-1:0]  column;
      logic [TK_ADDR_W-1:0] base;
      logic                 eof;
   } ticket_type;

   typedef struct packed {
      logic busy_reading;
      logic ticket_take;
   } back_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_RISE,
      BK_SWEEP,
      BK_FLUSH,
      BK_SCAN,
      BK_DIV,
      BK_PUSH
   } back_state_type;

endpackage
`default_nettype wire

FILE: hdl/opw_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
module opw_line_store
   import opw_pkg::*;
#(
   parameter int RADIUS    = RADIUS_DEFAULT,
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   localparam int DEPTH  = (2 * RADIUS + 1) * MAX_WIDTH,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [PIX_W-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [PIX_W-1:0]  rd_data
);

   logic [PIX_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: hdl/opw_front.sv
`timescale 1ns / 1ps
`default_nettype none
module opw_front
   import opw_pkg::*;
#(
   parameter int RADIUS    = RADIUS_DEFAULT,
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   localparam int COL_W  = $clog2(MAX_WIDTH),
   localparam int CW     = COL_W + 1,
   localparam int DEPTH  = (2 * RADIUS + 1) * MAX_WIDTH,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   input  wire req_type                req_data,
   output logic                        req_full,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output logic                        csr_ready,
   input  wire back_status_type        status,
   output logic                        ticket_valid,
   output ticket_type                  ticket,
   output logic                        wr_en,
   output logic      [ADDR_W-1:0]      wr_addr,
   output logic      [PIX_W-1:0]       wr_data,
   output logic      [CW-1:0]          width_eff,
   output logic      [FH_W-1:0]        height_eff
);

   logic [FW_W-1:0]   fw_ff, fw_in;
   logic [FH_W-1:0]   fh_ff, fh_in;
   logic [COL_W-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic              done_ff, done_in;
   logic [ADDR_W-1:0] wptr_ff, wptr_in, base_ff, base_in;
   logic              tk_valid_ff, tk_valid_in;
   ticket_type        tk_ff, tk_in;

   logic [FH_W-1:0]   w13, h13, need_r;
   logic [CW:0]       need_c;
   logic [ADDR_W:0]   wsum, bsum;
   logic              acc, pix, ready, emit, eof, csr_wr;

   always_comb begin
      w13 = FH_W'(fw_ff);
      if (w13 == '0) begin
         w13 = FH_W'(1);
      end else if (w13 > FH_W'(MAX_WIDTH)) begin
         w13 = FH_W'(MAX_WIDTH);
      end
      h13 = fh_ff;
      if (h13 == '0) begin
         h13 = FH_W'(1);
      end else if (h13 > FH_W'(MAX_HEIGHT)) begin
         h13 = FH_W'(MAX_HEIGHT);
      end
   end

   assign width_eff  = CW'(w13);
   assign height_eff = h13;
   assign csr_ready  = 1'b1;
   assign csr_wr     = csr_valid;
   assign req_full   = tk_valid_ff || status.busy_reading;
   assign acc        = req_push && !req_full;
   assign pix        = acc && (req_data.op == OP_PIXEL) && !done_ff;

   assign wr_en   = pix;
   assign wr_addr = wptr_ff;
   assign wr_data = {req_data.pixel_red, req_data.pixel_green, req_data.pixel_blue};

   assign ticket_valid = tk_valid_ff;
   assign ticket       = tk_ff;

   always_comb begin
      fw_in      = fw_ff;
      fh_in      = fh_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      done_in    = done_ff;
      wptr_in    = wptr_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      base_in    = base_ff;
      wsum       = (ADDR_W + 1)'(wptr_ff) + (ADDR_W + 1)'(1);
      bsum       = (ADDR_W + 1)'(base_ff) + (ADDR_W + 1)'(width_eff);

      // store the pixel and step the input position
      if (pix) begin
         if (CW'(in_col_ff) + CW'(1) >= width_eff) begin
            in_col_in = '0;
            if (FH_W'(in_row_ff) + FH_W'(1) >= h13) begin
               in_row_in = '0;
               done_in   = 1'b1;
            end else begin
               in_row_in = in_row_ff + ROW_W'(1);
            end
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (wsum >= (ADDR_W + 1)'(DEPTH)) begin
            wptr_in = '0;
         end else begin
            wptr_in = ADDR_W'(wsum);
         end
      end

      // is the next output covered by what has arrived
      need_r = FH_W'(out_row_ff) + FH_W'(RADIUS);
      if (need_r > h13 - FH_W'(1)) begin
         need_r = h13 - FH_W'(1);
      end
      need_c = (CW + 1)'(out_col_ff) + (CW + 1)'(RADIUS);
      if (need_c > (CW + 1)'(width_eff) - (CW + 1)'(1)) begin
         need_c = (CW + 1)'(width_eff) - (CW + 1)'(1);
      end
      ready = done_in || (need_r < FH_W'(in_row_in)) ||
              ((need_r == FH_W'(in_row_in)) && (need_c < (CW + 1)'(in_col_in)));
      emit  = acc && ((req_data.op == OP_DRAIN) || !done_ff) && ready;
      eof   = (FH_W'(out_row_ff) == h13 - FH_W'(1)) &&
              (CW'(out_col_ff) == width_eff - CW'(1));

      tk_in.row    = out_row_ff;
      tk_in.column = TK_COL_W'(out_col_ff);
      tk_in.base   = TK_ADDR_W'(base_ff);
      tk_in.eof    = eof;
      tk_valid_in  = (tk_valid_ff && !status.ticket_take) || emit;

      if (emit) begin
         if (eof) begin
            in_col_in  = '0;
            in_row_in  = '0;
            done_in    = 1'b0;
            wptr_in    = '0;
            out_col_in = '0;
            out_row_in = '0;
            base_in    = '0;
         end else if (CW'(out_col_ff) + CW'(1) >= width_eff) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ROW_W'(1);
            if (bsum >= (ADDR_W + 1)'(DEPTH)) begin
               base_in = ADDR_W'(bsum - (ADDR_W + 1)'(DEPTH));
            end else begin
               base_in = ADDR_W'(bsum);
            end
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end

      // a write to the width or height register restarts the frame
      if (csr_wr && ((csr_index == CSR_FRAME_WIDTH) || (csr_index == CSR_FRAME_HEIGHT))) begin
         if (csr_index == CSR_FRAME_WIDTH) begin
            fw_in = csr_data[FW_W-1:0];
         end else begin
            fh_in = csr_data[FH_W-1:0];
         end
         in_col_in  = '0;
         in_row_in  = '0;
         done_in    = 1'b0;
         wptr_in    = '0;
         out_col_in = '0;
         out_row_in = '0;
         base_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff       <= FRAME_WIDTH_RESET;
         fh_ff       <= FRAME_HEIGHT_RESET;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         done_ff     <= 1'b0;
         wptr_ff     <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         base_ff     <= '0;
         tk_valid_ff <= 1'b0;
      end else begin
         fw_ff       <= fw_in;
         fh_ff       <= fh_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         done_ff     <= done_in;
         wptr_ff     <= wptr_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         base_ff     <= base_in;
         tk_valid_ff <= tk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         tk_ff <= tk_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/opw_back.sv
`timescale 1ns / 1ps
`default_nettype none
module opw_back
   import opw_pkg::*;
#(
   parameter int RADIUS    = RADIUS_DEFAULT,
   parameter int LEVELS    = LEVELS_DEFAULT,
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   localparam int COL_W   = $clog2(MAX_WIDTH),
   localparam int CW      = COL_W + 1,
   localparam int DEPTH   = (2 * RADIUS + 1) * MAX_WIDTH,
   localparam int ADDR_W  = $clog2(DEPTH),
   localparam int WIN_PIX = (2 * RADIUS + 1) * (2 * RADIUS + 1),
   localparam int CNT_W   = $clog2(WIN_PIX + 1),
   localparam int SUM_W   = $clog2(WIN_PIX * 255 + 1),
   localparam int BIN_W   = $clog2(LEVELS),
   localparam int RISE_W  = $clog2(RADIUS + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              ticket_valid,
   input  wire ticket_type        ticket,
   output back_status_type        status,
   input  wire logic [CW-1:0]     width_eff,
   input  wire logic [FH_W-1:0]   height_eff,
   output logic                   rd_en,
   output logic      [ADDR_W-1:0] rd_addr,
   input  wire logic [PIX_W-1:0]  rd_data,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output rsp_type                rsp_data
);

   back_state_type state_ff, state_in;

   ticket_type        tk_ff;
   logic [ADDR_W-1:0] rowbase_ff;
   logic [RISE_W-1:0] rise_ff;
   logic [ROW_W-1:0]  y_ff, y1_ff;
   logic [CW-1:0]     x_ff, x0_ff, x1_ff;
   logic              v1_ff, v2_ff;
   logic [BIN_W-1:0]  bin2_ff, idx_ff, hidx;
   logic [7:0]        pr2_ff, pg2_ff, pb2_ff;

   logic [CNT_W-1:0]  cnt_ff [LEVELS];
   logic [SUM_W-1:0]  sr_ff  [LEVELS];
   logic [SUM_W-1:0]  sg_ff  [LEVELS];
   logic [SUM_W-1:0]  sb_ff  [LEVELS];

   logic [CNT_W-1:0]  best_cnt_ff, sel_cnt, den_ff;
   logic [SUM_W-1:0]  best_r_ff, best_g_ff, best_b_ff, sel_r, sel_g, sel_b;
   logic [SUM_W-1:0]  rem_r_ff, rem_g_ff, rem_b_ff, trial;
   logic [7:0]        q_r_ff, q_g_ff, q_b_ff;
   logic [2:0]        bit_ff;

   rsp_type           fifo_ff [2];
   logic              fwp_ff, frp_ff;
   logic [1:0]        fcnt_ff;
   logic              fifo_push, fifo_pop, take, last_col, last_row;

   logic [LEVELS-2:0] ge;
   logic [9:0]        isum;
   logic [ADDR_W:0]   asum, bsum, bdif;
   logic [FH_W-1:0]   y1_c;
   logic [CW:0]       x1_c;

   // intensity bin by threshold compare against each bin boundary
   assign isum = 10'(rd_data[23:16]) + 10'(rd_data[15:8]) + 10'(rd_data[7:0]);
   for (genvar k = 1; k < LEVELS; k++) begin : g_thr
      localparam int THR = (k * 765 + LEVELS - 1) / LEVELS;
      assign ge[k-1] = (isum >= 10'(THR));
   end

   assign last_col = (x_ff == x1_ff);
   assign last_row = (y_ff == y1_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:  if (ticket_valid) state_in = BK_RISE;
         BK_RISE:  if (rise_ff == '0) state_in = BK_SWEEP;
         BK_SWEEP: if (last_col && last_row) state_in = BK_FLUSH;
         BK_FLUSH: if (!v1_ff && !v2_ff) state_in = BK_SCAN;
         BK_SCAN:  if (idx_ff == BIN_W'(LEVELS - 1)) state_in = BK_DIV;
         BK_DIV:   if (bit_ff == '0) state_in = BK_PUSH;
         BK_PUSH:  if (fcnt_ff != 2'd2) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      take      = 1'b0;
      rd_en     = 1'b0;
      fifo_push = 1'b0;
      case (state_ff)
         BK_IDLE:  take      = ticket_valid;
         BK_SWEEP: rd_en     = 1'b1;
         BK_PUSH:  fifo_push = (fcnt_ff != 2'd2);
         default:  take      = 1'b0;
      endcase
   end

   assign status.ticket_take  = take;
   assign status.busy_reading = (state_ff == BK_RISE) || (state_ff == BK_SWEEP) ||
                                (state_ff == BK_FLUSH);

   always_comb begin
      asum = (ADDR_W + 1)'(rowbase_ff) + (ADDR_W + 1)'(x_ff);
      if (asum >= (ADDR_W + 1)'(DEPTH)) begin
         asum = asum - (ADDR_W + 1)'(DEPTH);
      end
      bsum = (ADDR_W + 1)'(rowbase_ff) + (ADDR_W + 1)'(width_eff);
      if (bsum >= (ADDR_W + 1)'(DEPTH)) begin
         bsum = bsum - (ADDR_W + 1)'(DEPTH);
      end
      if (rowbase_ff >= ADDR_W'(width_eff)) begin
         bdif = (ADDR_W + 1)'(rowbase_ff) - (ADDR_W + 1)'(width_eff);
      end else begin
         bdif = (ADDR_W + 1)'(rowbase_ff) + (ADDR_W + 1)'(DEPTH) -
                (ADDR_W + 1)'(width_eff);
      end
      y1_c = FH_W'(ticket.row) + FH_W'(RADIUS);
      if (y1_c > height_eff - FH_W'(1)) begin
         y1_c = height_eff - FH_W'(1);
      end
      x1_c = (CW + 1)'(ticket.column) + (CW + 1)'(RADIUS);
      if (x1_c > (CW + 1)'(width_eff) - (CW + 1)'(1)) begin
         x1_c = (CW + 1)'(width_eff) - (CW + 1)'(1);
      end
   end

   assign rd_addr = ADDR_W'(asum);
   assign hidx    = (state_ff == BK_SCAN) ? idx_ff : bin2_ff;

   always_comb begin
      if ((idx_ff == '0) || (cnt_ff[hidx] > best_cnt_ff)) begin
         sel_cnt = cnt_ff[hidx];
         sel_r   = sr_ff[hidx];
         sel_g   = sg_ff[hidx];
         sel_b   = sb_ff[hidx];
      end else begin
         sel_cnt = best_cnt_ff;
         sel_r   = best_r_ff;
         sel_g   = best_g_ff;
         sel_b   = best_b_ff;
      end
   end

   assign trial = SUM_W'(den_ff) << bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= rd_en;
         v2_ff    <= v1_ff;
      end
   end

   // window walk
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            tk_ff      <= ticket;
            rowbase_ff <= ADDR_W'(ticket.base);
            y1_ff      <= ROW_W'(y1_c);
            x1_ff      <= CW'(x1_c);
            if (ticket.row >= ROW_W'(RADIUS)) begin
               y_ff    <= ticket.row - ROW_W'(RADIUS);
               rise_ff <= RISE_W'(RADIUS);
            end else begin
               y_ff    <= '0;
               rise_ff <= RISE_W'(ticket.row);
            end
            if (CW'(ticket.column) >= CW'(RADIUS)) begin
               x_ff  <= CW'(ticket.column) - CW'(RADIUS);
               x0_ff <= CW'(ticket.column) - CW'(RADIUS);
            end else begin
               x_ff  <= '0;
               x0_ff <= '0;
            end
         end
         BK_RISE: begin
            if (rise_ff != '0) begin
               rowbase_ff <= ADDR_W'(bdif);
               rise_ff    <= rise_ff - RISE_W'(1);
            end
         end
         BK_SWEEP: begin
            if (last_col) begin
               x_ff       <= x0_ff;
               rowbase_ff <= ADDR_W'(bsum);
               y_ff       <= y_ff + ROW_W'(1);
            end else begin
               x_ff <= x_ff + CW'(1);
            end
         end
         default: begin
            x_ff <= x_ff;
         end
      endcase
   end

   // bin stage
   always_ff @(posedge clock) begin
      bin2_ff <= BIN_W'($countones(ge));
      pr2_ff  <= rd_data[23:16];
      pg2_ff  <= rd_data[15:8];
      pb2_ff  <= rd_data[7:0];
   end

   // histogram: accumulate as the sweep's reads return, read out and cleared by the scan
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            cnt_ff[i] <= '0;
            sr_ff[i]  <= '0;
            sg_ff[i]  <= '0;
            sb_ff[i]  <= '0;
         end
      end else if (state_ff == BK_SCAN) begin
         cnt_ff[hidx] <= '0;
         sr_ff[hidx]  <= '0;
         sg_ff[hidx]  <= '0;
         sb_ff[hidx]  <= '0;
      end else if (v2_ff) begin
         cnt_ff[hidx] <= cnt_ff[hidx] + CNT_W'(1);
         sr_ff[hidx]  <= sr_ff[hidx] + SUM_W'(pr2_ff);
         sg_ff[hidx]  <= sg_ff[hidx] + SUM_W'(pg2_ff);
         sb_ff[hidx]  <= sb_ff[hidx] + SUM_W'(pb2_ff);
      end
   end

   // fullest-bin scan, lowest bin kept on ties, then restoring divide
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_FLUSH: begin
            idx_ff <= '0;
         end
         BK_SCAN: begin
            idx_ff      <= idx_ff + BIN_W'(1);
            best_cnt_ff <= sel_cnt;
            best_r_ff   <= sel_r;
            best_g_ff   <= sel_g;
            best_b_ff   <= sel_b;
            rem_r_ff    <= sel_r;
            rem_g_ff    <= sel_g;
            rem_b_ff    <= sel_b;
            den_ff      <= (sel_cnt == '0) ? CNT_W'(1) : sel_cnt;
            bit_ff      <= 3'd7;
         end
         BK_DIV: begin
            bit_ff <= bit_ff - 3'd1;
            if (rem_r_ff >= trial) begin
               rem_r_ff <= rem_r_ff - trial;
               q_r_ff   <= {q_r_ff[6:0], 1'b1};
            end else begin
               q_r_ff   <= {q_r_ff[6:0], 1'b0};
            end
            if (rem_g_ff >= trial) begin
               rem_g_ff <= rem_g_ff - trial;
               q_g_ff   <= {q_g_ff[6:0], 1'b1};
            end else begin
               q_g_ff   <= {q_g_ff[6:0], 1'b0};
            end
            if (rem_b_ff >= trial) begin
               rem_b_ff <= rem_b_ff - trial;
               q_b_ff   <= {q_b_ff[6:0], 1'b1};
            end else begin
               q_b_ff   <= {q_b_ff[6:0], 1'b0};
            end
         end
         default: begin
            bit_ff <= bit_ff;
         end
      endcase
   end

   // two-entry result queue
   assign fifo_pop  = rsp_pop && (fcnt_ff != 2'd0);
   assign rsp_empty = (fcnt_ff == 2'd0);
   assign rsp_data  = fifo_ff[frp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         fwp_ff  <= 1'b0;
         frp_ff  <= 1'b0;
         fcnt_ff <= 2'd0;
      end else begin
         if (fifo_push) fwp_ff <= !fwp_ff;
         if (fifo_pop) frp_ff <= !frp_ff;
         fcnt_ff <= fcnt_ff + 2'(fifo_push) - 2'(fifo_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_ff[fwp_ff] <= '{out_red: q_r_ff, out_green: q_g_ff, out_blue: q_b_ff,
                              end_of_frame: tk_ff.eof};
      end
   end

   a_scan_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SCAN) |-> (!v1_ff && !v2_ff))
      else $error("histogram scan started with reads in flight");

   a_update_in_sweep: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> ((state_ff == BK_SWEEP) || (state_ff == BK_FLUSH)))
      else $error("histogram update outside the window sweep");

   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      take |=> (state_ff == BK_RISE))
      else $error("ticket taken without starting a window");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      fifo_push |=> !rsp_empty)
      else $error("result push lost");

endmodule
`default_nettype wire

FILE: hdl/oil_paint_window_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// an item that releases a result has it on rsp_data after the back rises r rows, reads the
//    N window pixels (up to (2*RADIUS+1)^2, one line-store read each), r = min(row, RADIUS),
//    scans the LEVELS bins, divides and queues it; no new ticket is taken before that push
// the front stalls (req_full) while a ticket waits or the back reads the line store
// reset: synchronous, active high; counters clear, registers to 640 x 480,
//    line store contents are left undefined and need no clearing pass
module oil_paint_window_filter
   import opw_pkg::*;
#(
   parameter int RADIUS    = RADIUS_DEFAULT,
   parameter int LEVELS    = LEVELS_DEFAULT,
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   input  wire req_type                req_data,
   output logic                        req_full,
   input  wire logic                   rsp_pop,
   output logic                        rsp_empty,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CW     = $clog2(MAX_WIDTH) + 1;
   localparam int ADDR_W = $clog2((2 * RADIUS + 1) * MAX_WIDTH);

   // front to back: one window ticket, plus status back
   back_status_type   status;
   ticket_type        ticket;
   logic              ticket_valid;

   // line store ports
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [PIX_W-1:0]  wr_data, rd_data;

   // effective frame geometry after clamping
   logic [CW-1:0]     width_eff;
   logic [FH_W-1:0]   height_eff;

   // front: takes pixels and drain ticks, writes the ring, issues output tickets
   opw_front #(
      .RADIUS    (RADIUS),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_data     (req_data),
      .req_full     (req_full),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .csr_ready    (csr_ready),
      .status       (status),
      .ticket_valid (ticket_valid),
      .ticket       (ticket),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .width_eff    (width_eff),
      .height_eff   (height_eff)
   );

   // ring of 2*RADIUS+1 rows
   opw_line_store #(
      .RADIUS    (RADIUS),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // back: window sweep, histogram, fullest bin, mean by serial divide
   opw_back #(
      .RADIUS    (RADIUS),
      .LEVELS    (LEVELS),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .ticket_valid (ticket_valid),
      .ticket       (ticket),
      .status       (status),
      .width_eff    (width_eff),
      .height_eff   (height_eff),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_data     (rsp_data)
   );

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import opw_pkg::*;

   localparam int WIN_R       = RADIUS_DEFAULT;
   localparam int BINS        = LEVELS_DEFAULT;
   localparam int ROW_MAX     = MAX_WIDTH_DEFAULT;
   localparam int STORE_DEPTH = (2 * WIN_R + 1) * ROW_MAX;
   // a window sweep plus bin scan and divide, with room to spare
   localparam int SETTLE_CYCLES = 400;
   localparam int STALL_LIMIT   = 20000;
   localparam int ITEM_GOAL     = 1450;

   // running model of the filter: line store, positions and expected results
   class window_mean_tracker;
      logic [PIX_W-1:0] line_store [STORE_DEPTH];
      logic [FW_W-1:0]  width_reg;
      logic [FH_W-1:0]  height_reg;
      int               col_in, row_in, col_out, row_out;
      bit               frame_in;
      rsp_type          pending_means[$];
      int               mismatches;
      int               results_seen;

      function void restart();
         col_in = 0; row_in = 0; col_out = 0; row_out = 0; frame_in = 0;
      endfunction

      function void clear();
         width_reg    = FRAME_WIDTH_RESET;
         height_reg   = FRAME_HEIGHT_RESET;
         mismatches   = 0;
         results_seen = 0;
         restart();
      endfunction

      function int cols();
         if (width_reg == 0) return 1;
         if (width_reg > ROW_MAX) return ROW_MAX;
         return int'(width_reg);
      endfunction

      function int rows();
         if (height_reg == 0) return 1;
         if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
         return int'(height_reg);
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_FRAME_WIDTH) begin
            width_reg = val[FW_W-1:0];
            restart();
         end else if (idx == CSR_FRAME_HEIGHT) begin
            height_reg = val[FH_W-1:0];
            restart();
         end
      endfunction

      // dominant-bin mean for the next output position, when its window is complete
      function void emit_next();
         int w, h, need_r, need_c, y0, y1, x0, x1, best, n, b;
         int cnt [BINS];
         int sr [BINS];
         int sg [BINS];
         int sb [BINS];
         logic [PIX_W-1:0] p;
         rsp_type res;
         w = cols();
         h = rows();
         need_r = (row_out + WIN_R > h - 1) ? h - 1 : row_out + WIN_R;
         need_c = (col_out + WIN_R > w - 1) ? w - 1 : col_out + WIN_R;
         if (!frame_in && need_r * w + need_c >= row_in * w + col_in) return;
         for (int i = 0; i < BINS; i++) begin
            cnt[i] = 0; sr[i] = 0; sg[i] = 0; sb[i] = 0;
         end
         y0 = (row_out >= WIN_R) ? row_out - WIN_R : 0;
         y1 = (row_out + WIN_R > h - 1) ? h - 1 : row_out + WIN_R;
         x0 = (col_out >= WIN_R) ? col_out - WIN_R : 0;
         x1 = (col_out + WIN_R > w - 1) ? w - 1 : col_out + WIN_R;
         for (int y = y0; y <= y1; y++) begin
            for (int x = x0; x <= x1; x++) begin
               p = line_store[(y * w + x) % STORE_DEPTH];
               b = (int'(p[23:16]) + int'(p[15:8]) + int'(p[7:0])) * BINS / 765;
               if (b > BINS - 1) b = BINS - 1;
               cnt[b]++;
               sr[b] += p[23:16];
               sg[b] += p[15:8];
               sb[b] += p[7:0];
            end
         end
         best = 0;
         for (int i = 1; i < BINS; i++)
            if (cnt[i] > cnt[best]) best = i;
         n = (cnt[best] != 0) ? cnt[best] : 1;
         res.out_red      = 8'(sr[best] / n);
         res.out_green    = 8'(sg[best] / n);
         res.out_blue     = 8'(sb[best] / n);
         res.end_of_frame = (row_out == h - 1) && (col_out == w - 1);
         pending_means = {pending_means, res};
         if (res.end_of_frame) begin
            restart();
         end else begin
            col_out++;
            if (col_out >= w) begin
               col_out = 0;
               row_out++;
            end
         end
      endfunction

      function void note_input(req_type item);
         if (item.op == OP_PIXEL) begin
            if (frame_in) return;
            line_store[(row_in * cols() + col_in) % STORE_DEPTH] =
               {item.pixel_red, item.pixel_green, item.pixel_blue};
            col_in++;
            if (col_in >= cols()) begin
               col_in = 0;
               row_in++;
               if (row_in >= rows()) begin
                  row_in = 0;
                  frame_in = 1;
               end
            end
         end
         emit_next();
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (pending_means.size() == 0) begin
            $error("result with nothing expected: %h", got);
            mismatches++;
            return;
         end
         want = pending_means.pop_front();
         if (got.out_red !== want.out_red) begin
            $error("out_red expected %0d actual %0d", want.out_red, got.out_red);
            mismatches++;
         end
         if (got.out_green !== want.out_green) begin
            $error("out_green expected %0d actual %0d", want.out_green, got.out_green);
            mismatches++;
         end
         if (got.out_blue !== want.out_blue) begin
            $error("out_blue expected %0d actual %0d", want.out_blue, got.out_blue);
            mismatches++;
         end
         if (got.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame expected %0d actual %0d", want.end_of_frame,
                   got.end_of_frame);
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_push  = 1'b0;
   req_type                req_data  = '0;
   logic                   req_full;
   logic                   rsp_pop   = 1'b0;
   logic                   rsp_empty;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   window_mean_tracker tracker = new();
   bit idle_on = 1'b1;       // random idling on both sides; cleared for the last stretch
   int items_sent = 0;
   int settings_run = 0;
   int quiet_cycles = 0;

   always #10 clock = ~clock;

   oil_paint_window_filter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // result side: check every transfer, stall pop in short random bursts
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) tracker.check_result(rsp_data);
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // watchdog: any stretch with no transfer on any channel that runs too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout with %0d results outstanding", tracker.pending_means.size());
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one input transfer, with an optional idle burst ahead of it
   task automatic push_item(req_type item);
      if (idle_on && $urandom_range(0, 6) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      tracker.note_input(item);
   endtask

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      req_type item;
      item.op          = OP_PIXEL;
      item.pixel_red   = r;
      item.pixel_green = g;
      item.pixel_blue  = b;
      if (!tracker.frame_in) items_sent++;
      push_item(item);
   endtask

   task automatic send_drain();
      req_type item;
      item = req_type'(25'($urandom()));
      item.op = OP_DRAIN;
      items_sent++;
      push_item(item);
   endtask

   // let every expected result out, then give the back end time to go idle
   task automatic settle();
      req_push <= 1'b0;
      while (tracker.pending_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // valid stays high on return so that writes can follow back to back
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, val);
   endtask

   task automatic set_frame(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h);
      settle();
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   // flush the rest of the frame once all pixels are in
   task automatic drain_frame();
      while (tracker.frame_in) send_drain();
   endtask

   task automatic random_pixel(logic [23:0] palette [4]);
      logic [23:0] c;
      c = ($urandom_range(0, 9) < 7) ? palette[$urandom_range(0, 3)] : 24'($urandom());
      send_pixel(c[23:16], c[15:8], c[7:0]);
   endtask

   initial begin
      logic [23:0] palette [4];
      int w, h, stop_at;
      tracker.clear();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset size 640 x 480: a few pixels and an early drain, nothing is ready yet
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_drain();
      send_pixel(8'd12, 8'd200, 8'd77);

      // tiny 3 x 2 frame: bin edges, channel extremes
      set_frame(13'd3, 13'd2);
      send_pixel(8'd51, 8'd51, 8'd50);   // sum 152, just below a bin edge
      send_pixel(8'd51, 8'd51, 8'd51);   // sum 153, just on it
      send_pixel(8'd255, 8'd0, 8'd0);
      send_drain();                      // window incomplete, nothing comes out
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd50, 8'd51, 8'd51);
      send_pixel(8'd9, 8'd9, 8'd9);      // frame already complete, ignored
      drain_frame();
      send_drain();                      // next frame not started, nothing ready

      // register extremes: zero and masked values clamp, plus the full range
      set_frame(13'd0, 13'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      set_frame(13'h1FFF, 13'd1);        // width masks to 2047, clamps to the maximum
      repeat (30) send_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()));
      set_frame(13'd1, 13'h1FFF);        // height clamps to the maximum
      repeat (30) send_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()));
      set_frame(13'd1024, 13'd4096);
      repeat (12) send_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()));
      set_frame(13'd1, 13'd1);
      send_pixel(8'd0, 8'd0, 8'd0);

      // random frames, mostly complete, some cut short or with stray items
      stop_at = ITEM_GOAL;
      while (items_sent < stop_at) begin
         if (items_sent > stop_at - 200) idle_on = 1'b0;
         if ($urandom_range(0, 7) == 0) begin
            w = $urandom_range(12, 40);
            h = $urandom_range(1, 2);
         end else begin
            w = $urandom_range(1, 14);
            h = $urandom_range(1, 14);
         end
         set_frame(CSR_DATA_W'(w), CSR_DATA_W'(h));
         for (int i = 0; i < 4; i++) palette[i] = 24'($urandom());
         if ($urandom_range(0, 9) == 0) begin
            // aborted frame: the next register write restarts it
            repeat ($urandom_range(1, w * h)) random_pixel(palette);
         end else begin
            while (!tracker.frame_in) begin
               if ($urandom_range(0, 11) == 0) send_drain();
               else random_pixel(palette);
            end
            if ($urandom_range(0, 3) == 0) random_pixel(palette);
            drain_frame();
         end
      end

      settle();
      $display("ran %0d items over %0d frame settings", items_sent, settings_run);
      $display("compared %0d results, %0d field mismatches", tracker.results_seen,
               tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending_means.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
hdl/opw_pkg.sv
hdl/opw_line_store.sv
hdl/opw_front.sv
hdl/opw_back.sv
hdl/oil_paint_window_filter.sv
tb/tb_top.sv
